// File: hw/rtl/ssa_pkg.sv
// Package for the sensor statistics accumulator: beat structs, codes and widths.
// No dependencies; imported by sensor_stats_accumulator, ssa_checker and testbench.
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

    // Default number of sensor table rows.
    localparam int NumSensorsDef = 128;
    localparam int NumKinds = 5;

    // Reading kinds.
    localparam logic [2:0] KIND_ENERGY = 3'd0;
    localparam logic [2:0] KIND_TEMP   = 3'd1;

    // Status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ALERT = 2'd1;
    localparam logic [1:0] STAT_CRIT = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SENSOR = 2'd1;
    localparam logic [1:0] ERR_KIND   = 2'd2;
    localparam logic [1:0] ERR_STATUS = 2'd3;

    // Input beat.
    typedef struct packed {
        logic [9:0]         sensor_number;
        logic [2:0]         reading_kind;
        logic signed [31:0] reading_value;
        logic [1:0]         reading_status;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [1:0]         error_code;
        logic [15:0]        sensor_reading_count;
        logic signed [47:0] kind_sum;
        logic [15:0]        temp_count;
        logic signed [31:0] temp_mean;
        logic signed [63:0] temp_m2;
        logic signed [55:0] energy_total;
        logic [31:0]        ok_total;
        logic [31:0]        alert_total;
        logic [31:0]        critical_total;
    } t_out;

    // One row of the per-sensor table.
    typedef struct packed {
        logic [15:0]                    cnt;
        logic [15:0]                    tcnt;
        logic signed [31:0]             mean;
        logic signed [63:0]             m2;
        logic [NumKinds-1:0][47:0]      ksum;
    } t_row;

endpackage
`default_nettype wire

// File: hw/rtl/sensor_stats_accumulator.sv
// Sensor statistics accumulator top level: per-sensor table, Welford update, tallies.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// An input beat (i_in) is taken at a rising edge where start is high and busy is low.
// Each beat yields exactly one result beat on o_res, marked by o_valid for one cycle.
// The receiver cannot stall; every result is taken in the cycle it appears.
// A beat with a bad sensor number, kind or status returns its error code in the cycle
// after acceptance, with all other fields zero, and busy stays low.
// A valid non-temperature beat holds busy through the update and write-back states; its
// result appears as busy drops, and the next beat can be taken while it is shown.
// A temperature beat adds a bit-serial restoring divide for the mean, a step for the
// new mean, a bit-serial shift-add multiply for the M2 term and saturation of the
// product and of the M2 sum, all with busy high; the next beat is taken only after
// its result, so these serial loops set the rate.
// After reset the table is cleared one row per cycle with busy high; the global tallies
// and the energy total are cleared at once by reset.
// One result beat is produced per accepted beat, in order.
module sensor_stats_accumulator
    import ssa_pkg::*;
#(
    parameter int NUM_SENSORS = NumSensorsDef
) (
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic start,
    output logic       busy,
    input  wire  t_in  i_in,
    output logic       o_valid,
    output t_out       o_res
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int DW = 33;
    localparam int CW = $clog2(DW + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_UPD   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_MEAN  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_PROD  = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_WB    = 4'd8;

    // Table memory.
    t_row r_mem [NUM_SENSORS];
    t_row r_rd;

    logic [3:0]  r_state;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_addr;
    t_in         r_in;
    t_row        r_row;
    logic signed [55:0] r_energy;
    logic [31:0] r_tally [3];
    logic        r_valid;
    t_out        r_out;

    // Serial datapath registers.
    logic [CW-1:0]      r_cnt;
    logic [DW-1:0]      r_dmag;
    logic [15:0]        r_rem;
    logic               r_dneg;
    logic signed [DW-1:0] r_delta;
    logic [2*DW-1:0]    r_ma;
    logic [DW-1:0]      r_mb;
    logic [2*DW-1:0]    r_prod;
    logic               r_pneg;
    logic signed [63:0] r_pval;

    // Input checks.
    logic [9:0]    w_idx10;
    logic [1:0]    w_err;
    logic          w_acc;
    t_out          n_err;
    assign w_idx10 = i_in.sensor_number - 10'd1;
    assign w_acc   = start && !busy;
    always_comb begin
        priority if (i_in.sensor_number == 10'd0 ||
                     {1'b0, i_in.sensor_number} > 11'(NUM_SENSORS)) begin
            w_err = ERR_SENSOR;
        end else if (i_in.reading_kind >= 3'(NumKinds)) begin
            w_err = ERR_KIND;
        end else if (i_in.reading_status == STAT_BAD) begin
            w_err = ERR_STATUS;
        end else begin
            w_err = ERR_NONE;
        end
        n_err            = '0;
        n_err.error_code = w_err;
    end
    assign busy = (r_state != ST_IDLE);

    // Memory port: one write and one registered read per cycle.
    logic          w_we;
    logic [AW-1:0] w_wa;
    t_row          w_wd;
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = r_row;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else if (r_state == ST_WB) begin
            w_we = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_idx10[AW-1:0]];
    end

    // Update arithmetic for the first pass over the read row.
    logic signed [48:0] w_ks;
    logic signed [47:0] w_ksat;
    logic signed [56:0] w_es;
    logic signed [32:0] w_dl;
    t_row               n_row;
    always_comb begin
        w_ks = {r_rd.ksum[r_in.reading_kind][47], r_rd.ksum[r_in.reading_kind]}
             + 49'(r_in.reading_value);
        if (w_ks[48] != w_ks[47]) begin
            w_ksat = w_ks[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            w_ksat = w_ks[47:0];
        end
        w_es = {r_energy[55], r_energy} + 57'(r_in.reading_value);
        w_dl = 33'(r_in.reading_value) - 33'(r_rd.mean);
        // Row with the counts and the kind sum updated.
        n_row = r_rd;
        if (r_rd.cnt != 16'hFFFF) begin
            n_row.cnt = r_rd.cnt + 16'd1;
        end
        n_row.ksum[r_in.reading_kind] = w_ksat;
        if (r_in.reading_kind == KIND_TEMP && r_rd.tcnt != 16'hFFFF) begin
            n_row.tcnt = r_rd.tcnt + 16'd1;
        end
    end

    // Divider step, mean and product terms.
    logic [16:0]        w_trial;
    logic               w_qb;
    logic signed [DW-1:0] w_q;
    logic signed [31:0] w_mean2;
    logic signed [DW-1:0] w_dl2;
    logic signed [64:0] w_m2s;
    always_comb begin
        w_trial = {r_rem, r_dmag[DW-1]};
        w_qb    = (w_trial >= {1'b0, r_row.tcnt});
        w_q     = r_dneg ? -$signed(r_dmag) : $signed(r_dmag);
        w_mean2 = r_row.mean + w_q[31:0];
        w_dl2   = 33'(r_in.reading_value) - 33'(w_mean2);
        w_m2s   = {r_row.m2[63], r_row.m2} + {r_pval[63], r_pval};
    end

    // Control and datapath sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_valid  <= 1'b0;
            r_energy <= '0;
            r_tally[0] <= '0;
            r_tally[1] <= '0;
            r_tally[2] <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NUM_SENSORS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc) begin
                        r_in   <= i_in;
                        r_addr <= w_idx10[AW-1:0];
                        if (w_err != ERR_NONE) begin
                            r_out   <= n_err;
                            r_valid <= 1'b1;
                        end else begin
                            r_state <= ST_UPD;
                        end
                    end
                end
                ST_UPD: begin
                    r_row <= n_row;
                    if (r_in.reading_kind == KIND_ENERGY) begin
                        if (w_es[56] != w_es[55]) begin
                            r_energy <= w_es[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
                        end else begin
                            r_energy <= w_es[55:0];
                        end
                    end
                    if (r_tally[r_in.reading_status] != 32'hFFFF_FFFF) begin
                        r_tally[r_in.reading_status] <= r_tally[r_in.reading_status] + 32'd1;
                    end
                    if (r_in.reading_kind == KIND_TEMP) begin
                        r_delta <= w_dl;
                        r_dneg  <= w_dl[32];
                        r_dmag  <= w_dl[32] ? DW'(-w_dl) : DW'(w_dl);
                        r_rem   <= '0;
                        r_cnt   <= CW'(DW);
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_WB;
                    end
                end
                ST_DIV: begin
                    // One quotient bit per cycle, restoring.
                    r_rem  <= w_qb ? 16'(w_trial - {1'b0, r_row.tcnt}) : w_trial[15:0];
                    r_dmag <= {r_dmag[DW-2:0], w_qb};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    r_row.mean <= w_mean2;
                    r_ma   <= (2*DW)'(r_delta[DW-1] ? DW'(-r_delta) : DW'(r_delta));
                    r_mb   <= w_dl2[DW-1] ? DW'(-w_dl2) : DW'(w_dl2);
                    r_pneg <= r_delta[DW-1] ^ w_dl2[DW-1];
                    r_prod <= '0;
                    r_cnt  <= CW'(DW);
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // One multiplier bit per cycle, shift and add.
                    if (r_mb[0]) begin
                        r_prod <= r_prod + r_ma;
                    end
                    r_ma  <= {r_ma[2*DW-2:0], 1'b0};
                    r_mb  <= {1'b0, r_mb[DW-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    if (r_prod[2*DW-1:63] != '0) begin
                        r_pval <= r_pneg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        r_pval <= r_pneg ? -$signed(r_prod[63:0]) : $signed(r_prod[63:0]);
                    end
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (w_m2s[64] != w_m2s[63]) begin
                        r_row.m2 <= w_m2s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        r_row.m2 <= w_m2s[63:0];
                    end
                    r_state <= ST_WB;
                end
                ST_WB: begin
                    r_out.error_code           <= ERR_NONE;
                    r_out.sensor_reading_count <= r_row.cnt;
                    r_out.kind_sum             <= r_row.ksum[r_in.reading_kind];
                    r_out.temp_count           <= r_row.tcnt;
                    r_out.temp_mean            <= r_row.mean;
                    r_out.temp_m2              <= r_row.m2;
                    r_out.energy_total         <= r_energy;
                    r_out.ok_total             <= r_tally[STAT_OK];
                    r_out.alert_total          <= r_tally[STAT_ALERT];
                    r_out.critical_total       <= r_tally[STAT_CRIT];
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

    // An error result carries no statistics: its reading count is zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.error_code != ERR_NONE |-> o_res.sensor_reading_count == 16'd0)
        else $error("error result carries a nonzero count");

    // A good result always follows at least one counted reading.
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.error_code == ERR_NONE |-> o_res.sensor_reading_count != 16'd0)
        else $error("good result with zero reading count");

    // No result straight out of reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

endmodule
`default_nettype wire

// File: bench/ssa_checker.sv
// Checker for the sensor statistics accumulator: predicts each result beat and compares it.
// Depends on ssa_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps
`default_nettype none
module ssa_checker
    import ssa_pkg::*;
#(
    parameter int NUM_SENSORS = NumSensorsDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_in  i_in,
    input  wire logic i_valid,
    input  wire t_out i_res,
    output int        o_errors,
    output int        o_pending
);

    localparam longint M2Max = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint M2Min = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    // Shadow copy of the block's state.
    logic [15:0]        cnt_tbl  [NUM_SENSORS];
    logic [15:0]        tcnt_tbl [NUM_SENSORS];
    logic signed [31:0] mean_tbl [NUM_SENSORS];
    logic signed [63:0] m2_tbl   [NUM_SENSORS];
    logic signed [47:0] ksum_tbl [NUM_SENSORS*NumKinds];
    logic signed [55:0] energy_acc;
    logic [31:0]        tally [3];

    t_out expected_q[$];
    int   errors;

    assign o_errors  = errors;
    assign o_pending = expected_q.size();

    // Clamp a wide sum into a signed field of w bits.
    function automatic longint clamp_w(longint s, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (s > hi) return hi;
        if (s < lo) return lo;
        return s;
    endfunction

    // Apply one reading to the shadow state and return the result it yields.
    function automatic t_out apply_reading(t_in r);
        t_out o;
        int s, k;
        longint v, mean, delta, q, mean2, delta2, n;
        logic signed [127:0] prod, m2sum;
        o = '0;
        if (r.sensor_number == 0 || r.sensor_number > NUM_SENSORS) begin
            o.error_code = ERR_SENSOR;
            return o;
        end
        if (r.reading_kind >= NumKinds) begin
            o.error_code = ERR_KIND;
            return o;
        end
        if (r.reading_status == STAT_BAD) begin
            o.error_code = ERR_STATUS;
            return o;
        end
        s = r.sensor_number - 1;
        k = s * NumKinds + r.reading_kind;
        v = longint'(r.reading_value);
        if (cnt_tbl[s] != 16'hFFFF) cnt_tbl[s]++;
        ksum_tbl[k] = 48'(clamp_w(longint'(ksum_tbl[k]) + v, 48));
        if (r.reading_kind == KIND_ENERGY)
            energy_acc = 56'(clamp_w(longint'(energy_acc) + v, 56));
        // Welford update with truncating division.
        if (r.reading_kind == KIND_TEMP) begin
            if (tcnt_tbl[s] != 16'hFFFF) tcnt_tbl[s]++;
            n = longint'(tcnt_tbl[s]);
            mean = longint'(mean_tbl[s]);
            delta = v - mean;
            q = delta / n;
            mean2 = mean + q;
            delta2 = v - mean2;
            mean_tbl[s] = mean2[31:0];
            prod = 128'(signed'(delta)) * 128'(signed'(delta2));
            if (prod > 128'(M2Max)) prod = 128'(M2Max);
            if (prod < 128'(M2Min)) prod = 128'(M2Min);
            m2sum = 128'(signed'(m2_tbl[s])) + prod;
            if (m2sum > 128'(M2Max)) m2sum = 128'(M2Max);
            if (m2sum < 128'(M2Min)) m2sum = 128'(M2Min);
            m2_tbl[s] = m2sum[63:0];
        end
        if (tally[r.reading_status] != 32'hFFFF_FFFF) tally[r.reading_status]++;
        o.sensor_reading_count = cnt_tbl[s];
        o.kind_sum             = ksum_tbl[k];
        o.temp_count           = tcnt_tbl[s];
        o.temp_mean            = mean_tbl[s];
        o.temp_m2              = m2_tbl[s];
        o.energy_total         = energy_acc;
        o.ok_total             = tally[STAT_OK];
        o.alert_total          = tally[STAT_ALERT];
        o.critical_total       = tally[STAT_CRIT];
        return o;
    endfunction

    // Predict on each accepted reading, then compare each result beat.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            foreach (cnt_tbl[i]) begin
                cnt_tbl[i] = '0; tcnt_tbl[i] = '0; mean_tbl[i] = '0; m2_tbl[i] = '0;
            end
            foreach (ksum_tbl[i]) ksum_tbl[i] = '0;
            energy_acc = '0;
            foreach (tally[i]) tally[i] = '0;
            expected_q.delete();
            errors = 0;
        end else begin
            if (i_start && !i_busy) expected_q.push_back(apply_reading(i_in));
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with no reading pending");
                    errors++;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_res.error_code !== exp_res.error_code) begin
                        $error("error_code exp %0d got %0d", exp_res.error_code,
                               i_res.error_code); errors++; end
                    if (i_res.sensor_reading_count !== exp_res.sensor_reading_count) begin
                        $error("sensor_reading_count exp %0d got %0d",
                               exp_res.sensor_reading_count, i_res.sensor_reading_count);
                        errors++; end
                    if (i_res.kind_sum !== exp_res.kind_sum) begin
                        $error("kind_sum exp %0d got %0d", exp_res.kind_sum,
                               i_res.kind_sum); errors++; end
                    if (i_res.temp_count !== exp_res.temp_count) begin
                        $error("temp_count exp %0d got %0d", exp_res.temp_count,
                               i_res.temp_count); errors++; end
                    if (i_res.temp_mean !== exp_res.temp_mean) begin
                        $error("temp_mean exp %0d got %0d", exp_res.temp_mean,
                               i_res.temp_mean); errors++; end
                    if (i_res.temp_m2 !== exp_res.temp_m2) begin
                        $error("temp_m2 exp %0d got %0d", exp_res.temp_m2,
                               i_res.temp_m2); errors++; end
                    if (i_res.energy_total !== exp_res.energy_total) begin
                        $error("energy_total exp %0d got %0d", exp_res.energy_total,
                               i_res.energy_total); errors++; end
                    if (i_res.ok_total !== exp_res.ok_total) begin
                        $error("ok_total exp %0d got %0d", exp_res.ok_total,
                               i_res.ok_total); errors++; end
                    if (i_res.alert_total !== exp_res.alert_total) begin
                        $error("alert_total exp %0d got %0d", exp_res.alert_total,
                               i_res.alert_total); errors++; end
                    if (i_res.critical_total !== exp_res.critical_total) begin
                        $error("critical_total exp %0d got %0d", exp_res.critical_total,
                               i_res.critical_total); errors++; end
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Testbench top for the sensor statistics accumulator: clock, reset, stimulus, verdict.
// Depends on ssa_pkg, sensor_stats_accumulator and ssa_checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import ssa_pkg::*;

    localparam int NSens     = NumSensorsDef;
    localparam int StallMax  = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_in = '0;
    logic o_valid;
    t_out o_res;
    int   errors, pending;
    int   idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sensor_stats_accumulator #(.NUM_SENSORS(NSens)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_valid(o_valid), .o_res(o_res)
    );

    ssa_checker #(.NUM_SENSORS(NSens)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_in(i_in),
        .i_valid(o_valid), .i_res(o_res), .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: too long without any accepted beat or result beat ends the run.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallMax) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one reading and hold it until the block takes it.
    task automatic send_reading(logic [9:0] num, logic [2:0] kind, logic [31:0] val,
                                logic [1:0] stat);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= '{sensor_number: num, reading_kind: kind, reading_value: val,
                   reading_status: stat};
        do @(posedge i_clk); while (busy);
    endtask

    // Random value mostly near a typical temperature, sometimes extreme.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 80 << 16)) - (20 << 16));
        endcase
    endfunction

    initial begin
        logic [1:0] st;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors, priority, extremes, each kind and status.
        send_reading(10'd0, 3'd7, 32'd0, STAT_BAD);
        send_reading(10'd1023, 3'd0, 32'd5, STAT_OK);
        send_reading(10'(NSens + 1), 3'd0, 32'd5, STAT_OK);
        send_reading(10'd1, 3'd5, 32'd5, STAT_BAD);
        send_reading(10'd1, 3'd6, 32'd5, STAT_OK);
        send_reading(10'd1, KIND_ENERGY, 32'd5, STAT_BAD);
        for (int k = 0; k < NumKinds; k++)
            send_reading(10'd1, 3'(k), 32'h0001_8000, 2'(k % 3));
        send_reading(10'(NSens), KIND_ENERGY, 32'h7FFF_FFFF, STAT_ALERT);
        send_reading(10'(NSens), KIND_ENERGY, 32'h8000_0000, STAT_CRIT);
        send_reading(10'd2, KIND_TEMP, 32'h7FFF_FFFF, STAT_OK);
        send_reading(10'd2, KIND_TEMP, 32'h8000_0000, STAT_OK);
        send_reading(10'd2, KIND_TEMP, 32'h7FFF_FFFF, STAT_OK);
        send_reading(10'd2, KIND_TEMP, 32'hFFFF_FFFF, STAT_OK);
        send_reading(10'd2, KIND_TEMP, 32'h0000_0001, STAT_OK);
        // Drive the M2 of sensor 3 into saturation with alternating extremes.
        for (int i = 0; i < 6; i++)
            send_reading(10'd3, KIND_TEMP, (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, STAT_OK);

        // Random: mostly valid readings over a few hot sensors, some noise.
        for (int i = 0; i < 950; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_reading(10'($urandom()), 3'($urandom()), $urandom(), 2'($urandom()));
            end else begin
                st = 2'($urandom_range(0, 2));
                send_reading(10'($urandom_range(0, 3) == 0 ? $urandom_range(1, NSens)
                                                           : $urandom_range(1, 6)),
                             $urandom_range(0, 1) ? KIND_TEMP : 3'($urandom_range(0, 4)),
                             pick_value(), st);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
